/* src/ray_triangle_intersect_top_assert.svh */
// ----------------------------------------------------------------------------
// ray triangle intersect assertion macros
// shared property wrappers for the intersect pipeline, clocked on clk and
// disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef RAY_TRIANGLE_INTERSECT_TOP_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_TOP_ASSERT_SVH

// same-cycle implication
`define RTI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rti: same-cycle check failed");

// next-cycle implication
`define RTI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rti: next-cycle check failed");

`endif

/* src/rti_pkg.sv */
// ----------------------------------------------------------------------------
// rti_pkg
// widths, payload types and arithmetic helpers for the ray triangle test
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rti_pkg;

	localparam int COORD_BITS = 16;
	localparam int FIELD_W    = 48;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int CROSS_W    = PROD_W + 1;
	localparam int DPROD_W    = DIFF_W + CROSS_W;
	localparam int DOT_W      = DPROD_W + 2;
	localparam int MAG_W      = DOT_W - 1;
	localparam int PARAM_W    = 24;
	localparam int INT_BITS   = 8;
	localparam int DIV_W      = DOT_W + INT_BITS;
	localparam int DIV_LAST   = PARAM_W - 1;
	localparam logic [PARAM_W-1:0] PARAM_MAX = '1;

	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [CROSS_W-1:0] cross_t;
	typedef logic signed [DPROD_W-1:0] dprod_t;
	typedef logic signed [DOT_W-1:0]   dot_t;

	typedef struct packed {
		diff_t x;
		diff_t y;
		diff_t z;
	} dvec_t;

	typedef struct packed {
		cross_t x;
		cross_t y;
		cross_t z;
	} cvec_t;

	typedef struct packed {
		logic [FIELD_W-1:0] ray_origin;
		logic [FIELD_W-1:0] ray_through;
		logic [FIELD_W-1:0] vertex_a;
		logic [FIELD_W-1:0] vertex_b;
		logic [FIELD_W-1:0] vertex_c;
	} rti_req_t;

	typedef struct packed {
		logic               hit;
		logic [PARAM_W-1:0] ray_param;
	} rti_rsp_t;

	// geometry verdict handed to the divider
	typedef struct packed {
		logic             hit;
		logic             sat;
		logic [MAG_W-1:0] t;
		logic [MAG_W-1:0] denom;
	} rti_geo_t;

	function automatic diff_t coord_diff(logic [FIELD_W-1:0] f, logic [FIELD_W-1:0] g,
		int k);
		logic signed [COORD_BITS-1:0] cf;
		logic signed [COORD_BITS-1:0] cg;
		cf = f[k*COORD_BITS +: COORD_BITS];
		cg = g[k*COORD_BITS +: COORD_BITS];
		return DIFF_W'(cf) - DIFF_W'(cg);
	endfunction

	function automatic dvec_t vdiff(logic [FIELD_W-1:0] f, logic [FIELD_W-1:0] g);
		dvec_t r;
		r.x = coord_diff(f, g, 0);
		r.y = coord_diff(f, g, 1);
		r.z = coord_diff(f, g, 2);
		return r;
	endfunction

	function automatic prod_t mul_dd(diff_t a, diff_t b);
		prod_t ea;
		prod_t eb;
		ea = PROD_W'(a);
		eb = PROD_W'(b);
		return ea * eb;
	endfunction

	function automatic dprod_t mul_dc(diff_t a, cross_t b);
		dprod_t ea;
		dprod_t eb;
		ea = DPROD_W'(a);
		eb = DPROD_W'(b);
		return ea * eb;
	endfunction

	function automatic cross_t csub(prod_t a, prod_t b);
		return CROSS_W'(a) - CROSS_W'(b);
	endfunction

	function automatic dot_t dsum(dprod_t a, dprod_t b, dprod_t c);
		return DOT_W'(a) + DOT_W'(b) + DOT_W'(c);
	endfunction

endpackage

/* src/rti_front.sv */
// ----------------------------------------------------------------------------
// rti_front
// six-stage geometry pipe: edge vectors, cross products, dot products and
// the accept / reject decision with saturation flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ray_triangle_intersect_top_assert.svh"

module rti_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  rti_pkg::rti_req_t req,
	output logic              geo_valid,
	output rti_pkg::rti_geo_t geo
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	rti_pkg::dvec_t  ba_s1, ca_s1, pq_s1, pa_s1;
	rti_pkg::dvec_t  ba_s2, ca_s2, pq_s2, pa_s2;
	rti_pkg::dvec_t  ba_s3, ca_s3, pq_s3, pa_s3;
	rti_pkg::prod_t  nprod_s2 [6];
	rti_pkg::prod_t  eprod_s2 [6];
	rti_pkg::cvec_t  n_s3, e_s3;
	rti_pkg::dprod_t dp_s4 [12];
	rti_pkg::dot_t   denom_s5, t_s5, v_s5, bae_s5;
	rti_pkg::rti_geo_t geo_s6;

	logic signed [rti_pkg::DOT_W:0] vw;
	logic [rti_pkg::MAG_W+rti_pkg::INT_BITS-1:0] t_ext, d_shift;
	logic denom_ok, t_ok, v_ok, w_ok, vw_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// stage 1: edge and ray vectors
	always_ff @(posedge clk) begin
		if (en) begin
			ba_s1 <= rti_pkg::vdiff(req.vertex_b, req.vertex_a);
			ca_s1 <= rti_pkg::vdiff(req.vertex_c, req.vertex_a);
			pq_s1 <= rti_pkg::vdiff(req.ray_origin, req.ray_through);
			pa_s1 <= rti_pkg::vdiff(req.ray_origin, req.vertex_a);
		end
	end

	// stage 2: cross product terms for n = ba x ca and e = pq x pa
	always_ff @(posedge clk) begin
		if (en) begin
			nprod_s2[0] <= rti_pkg::mul_dd(ba_s1.y, ca_s1.z);
			nprod_s2[1] <= rti_pkg::mul_dd(ba_s1.z, ca_s1.y);
			nprod_s2[2] <= rti_pkg::mul_dd(ba_s1.z, ca_s1.x);
			nprod_s2[3] <= rti_pkg::mul_dd(ba_s1.x, ca_s1.z);
			nprod_s2[4] <= rti_pkg::mul_dd(ba_s1.x, ca_s1.y);
			nprod_s2[5] <= rti_pkg::mul_dd(ba_s1.y, ca_s1.x);
			eprod_s2[0] <= rti_pkg::mul_dd(pq_s1.y, pa_s1.z);
			eprod_s2[1] <= rti_pkg::mul_dd(pq_s1.z, pa_s1.y);
			eprod_s2[2] <= rti_pkg::mul_dd(pq_s1.z, pa_s1.x);
			eprod_s2[3] <= rti_pkg::mul_dd(pq_s1.x, pa_s1.z);
			eprod_s2[4] <= rti_pkg::mul_dd(pq_s1.x, pa_s1.y);
			eprod_s2[5] <= rti_pkg::mul_dd(pq_s1.y, pa_s1.x);
			ba_s2 <= ba_s1;
			ca_s2 <= ca_s1;
			pq_s2 <= pq_s1;
			pa_s2 <= pa_s1;
		end
	end

	// stage 3: finish the cross products
	always_ff @(posedge clk) begin
		if (en) begin
			n_s3.x <= rti_pkg::csub(nprod_s2[0], nprod_s2[1]);
			n_s3.y <= rti_pkg::csub(nprod_s2[2], nprod_s2[3]);
			n_s3.z <= rti_pkg::csub(nprod_s2[4], nprod_s2[5]);
			e_s3.x <= rti_pkg::csub(eprod_s2[0], eprod_s2[1]);
			e_s3.y <= rti_pkg::csub(eprod_s2[2], eprod_s2[3]);
			e_s3.z <= rti_pkg::csub(eprod_s2[4], eprod_s2[5]);
			ba_s3 <= ba_s2;
			ca_s3 <= ca_s2;
			pq_s3 <= pq_s2;
			pa_s3 <= pa_s2;
		end
	end

	// stage 4: dot product terms
	always_ff @(posedge clk) begin
		if (en) begin
			dp_s4[0]  <= rti_pkg::mul_dc(pq_s3.x, n_s3.x);
			dp_s4[1]  <= rti_pkg::mul_dc(pq_s3.y, n_s3.y);
			dp_s4[2]  <= rti_pkg::mul_dc(pq_s3.z, n_s3.z);
			dp_s4[3]  <= rti_pkg::mul_dc(pa_s3.x, n_s3.x);
			dp_s4[4]  <= rti_pkg::mul_dc(pa_s3.y, n_s3.y);
			dp_s4[5]  <= rti_pkg::mul_dc(pa_s3.z, n_s3.z);
			dp_s4[6]  <= rti_pkg::mul_dc(ca_s3.x, e_s3.x);
			dp_s4[7]  <= rti_pkg::mul_dc(ca_s3.y, e_s3.y);
			dp_s4[8]  <= rti_pkg::mul_dc(ca_s3.z, e_s3.z);
			dp_s4[9]  <= rti_pkg::mul_dc(ba_s3.x, e_s3.x);
			dp_s4[10] <= rti_pkg::mul_dc(ba_s3.y, e_s3.y);
			dp_s4[11] <= rti_pkg::mul_dc(ba_s3.z, e_s3.z);
		end
	end

	// stage 5: denom, t, v and ba.e (w is its negation)
	always_ff @(posedge clk) begin
		if (en) begin
			denom_s5 <= rti_pkg::dsum(dp_s4[0], dp_s4[1], dp_s4[2]);
			t_s5     <= rti_pkg::dsum(dp_s4[3], dp_s4[4], dp_s4[5]);
			v_s5     <= rti_pkg::dsum(dp_s4[6], dp_s4[7], dp_s4[8]);
			bae_s5   <= rti_pkg::dsum(dp_s4[9], dp_s4[10], dp_s4[11]);
		end
	end

	// stage 6: accept / reject, w >= 0 is ba.e <= 0 and v + w is v - ba.e
	always_comb begin
		vw       = (rti_pkg::DOT_W+1)'(v_s5) - (rti_pkg::DOT_W+1)'(bae_s5);
		denom_ok = !denom_s5[rti_pkg::DOT_W-1] && (denom_s5 != '0);
		t_ok     = !t_s5[rti_pkg::DOT_W-1];
		v_ok     = !v_s5[rti_pkg::DOT_W-1] && (v_s5 <= denom_s5);
		w_ok     = bae_s5[rti_pkg::DOT_W-1] || (bae_s5 == '0);
		vw_ok    = vw <= (rti_pkg::DOT_W+1)'(denom_s5);
		t_ext    = (rti_pkg::MAG_W+rti_pkg::INT_BITS)'(t_s5[rti_pkg::MAG_W-1:0]);
		d_shift  = {denom_s5[rti_pkg::MAG_W-1:0], {rti_pkg::INT_BITS{1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s6.hit   <= denom_ok && t_ok && v_ok && w_ok && vw_ok;
			geo_s6.sat   <= t_ext >= d_shift;
			geo_s6.t     <= t_s5[rti_pkg::MAG_W-1:0];
			geo_s6.denom <= denom_s5[rti_pkg::MAG_W-1:0];
		end
	end

	assign geo_valid = valid_s6;
	assign geo       = geo_s6;

	`RTI_ASSERT_IMP(a_hit_denom_nonzero, geo_valid && geo.hit, geo.denom != '0)
	`RTI_ASSERT_NXT(a_geo_hold_on_stall, !en, $stable(geo_valid) && $stable(geo))

endmodule

/* src/rti_div.sv */
// ----------------------------------------------------------------------------
// rti_div
// pipelined restoring divider, one quotient bit per stage, giving t / denom
// in Q8.16 with miss and saturation applied at the last stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ray_triangle_intersect_top_assert.svh"

module rti_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              geo_valid,
	input  rti_pkg::rti_geo_t geo,
	output logic              res_valid,
	output rti_pkg::rti_rsp_t res
);

	logic                        vld_s [rti_pkg::PARAM_W];
	logic                        hit_s [rti_pkg::PARAM_W];
	logic                        sat_s [rti_pkg::PARAM_W];
	logic [rti_pkg::DIV_W-1:0]   rem_s [rti_pkg::PARAM_W];
	logic [rti_pkg::DIV_W-1:0]   dsh_s [rti_pkg::PARAM_W];
	logic [rti_pkg::PARAM_W-1:0] quo_s [rti_pkg::PARAM_W];

	// remainder stays below 2 * (denom << 7), so each step is one compare-subtract
	for (genvar i = 0; i < rti_pkg::PARAM_W; i++) begin : g_step
		logic                        vld_in, hit_in, sat_in, ge;
		logic [rti_pkg::DIV_W-1:0]   rem_in, dsh_in, rem_nx;
		logic [rti_pkg::PARAM_W-1:0] quo_in;

		if (i == 0) begin : g_first
			assign vld_in = geo_valid;
			assign hit_in = geo.hit;
			assign sat_in = geo.sat;
			assign rem_in = rti_pkg::DIV_W'(geo.t);
			assign dsh_in = rti_pkg::DIV_W'({geo.denom, {(rti_pkg::INT_BITS-1){1'b0}}});
			assign quo_in = '0;
		end else begin : g_next
			assign vld_in = vld_s[i-1];
			assign hit_in = hit_s[i-1];
			assign sat_in = sat_s[i-1];
			assign rem_in = rem_s[i-1];
			assign dsh_in = dsh_s[i-1];
			assign quo_in = quo_s[i-1];
		end

		assign ge     = rem_in >= dsh_in;
		assign rem_nx = ge ? (rem_in - dsh_in) : rem_in;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				hit_s[i] <= hit_in;
				sat_s[i] <= sat_in;
				rem_s[i] <= {rem_nx[rti_pkg::DIV_W-2:0], 1'b0};
				dsh_s[i] <= dsh_in;
				quo_s[i] <= {quo_in[rti_pkg::PARAM_W-2:0], ge};
			end
		end
	end

	always_comb begin
		res_valid = vld_s[rti_pkg::DIV_LAST];
		res.hit   = hit_s[rti_pkg::DIV_LAST];
		if (!hit_s[rti_pkg::DIV_LAST]) begin
			res.ray_param = '0;
		end else if (sat_s[rti_pkg::DIV_LAST]) begin
			res.ray_param = rti_pkg::PARAM_MAX;
		end else begin
			res.ray_param = quo_s[rti_pkg::DIV_LAST];
		end
	end

	`RTI_ASSERT_IMP(a_rem_bound_first, vld_s[0] && hit_s[0] && !sat_s[0], rem_s[0] < (dsh_s[0] << 1))
	`RTI_ASSERT_IMP(a_rem_bound_last, res_valid && res.hit && !sat_s[rti_pkg::DIV_LAST], rem_s[rti_pkg::DIV_LAST] < (dsh_s[rti_pkg::DIV_LAST] << 1))

endmodule

/* src/ray_triangle_intersect_top.sv */
// ----------------------------------------------------------------------------
// ray_triangle_intersect_top
// front-face ray / triangle test with the hit parameter as unsigned Q8.16
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   rti_req_t: p, q, a, b, c
//   rsp      out        rsp_valid/rsp_stall   rti_rsp_t: hit, ray_param
//
// one request per cycle while the pipeline enable is high; 6 geometry stages,
// 24 divider stages, output register
// one global pipeline enable, lowered only while a result is held on rsp
// and rsp_stall is high; req_stall is that same condition
// reset clears the valid bits only, no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ray_triangle_intersect_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  rti_pkg::rti_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rti_pkg::rti_rsp_t rsp
);

	logic              en;
	logic              geo_valid;
	rti_pkg::rti_geo_t geo;
	logic              res_valid;
	rti_pkg::rti_rsp_t res;
	logic              rsp_valid_q;
	rti_pkg::rti_rsp_t rsp_q;

	// the whole pipe moves unless the output slot is full and held
	assign en        = !(rsp_valid_q && rsp_stall);
	assign req_stall = !en;

	rti_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (req_valid),
		.req       (req),
		.geo_valid (geo_valid),
		.geo       (geo)
	);

	rti_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.geo_valid (geo_valid),
		.geo       (geo),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
